[rtl/core/rrt_pkg.sv]
`timescale 1ns / 1ps

package rrt_pkg;

  // Table geometry
  localparam int TableDepth = 16;
  localparam int SlotW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  // Fixed field widths
  localparam int IdW     = 32;
  localparam int AddrW   = 32;
  localparam int PortW   = 16;
  localparam int TimeW   = 32;
  localparam int CfgW    = 8;
  localparam int CfgIdxW = 1;
  localparam int KeyW    = IdW + AddrW + PortW;

  // Request types
  localparam logic [1:0] ReqNew   = 2'd0;
  localparam logic [1:0] ReqReply = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  // Result status codes
  localparam logic [2:0] StsStored    = 3'd0;
  localparam logic [2:0] StsFull      = 3'd1;
  localparam logic [2:0] StsMatched   = 3'd2;
  localparam logic [2:0] StsUnmatched = 3'd3;
  localparam logic [2:0] StsIgnored   = 3'd4;
  localparam logic [2:0] StsResend    = 3'd5;
  localparam logic [2:0] StsExpired   = 3'd6;
  localparam logic [2:0] StsTickDone  = 3'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgResendGap = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLifetime  = 1'd1;

  // Where a result's slot and fields come from
  typedef enum logic [1:0] {
    SrcEcho  = 2'd0,
    SrcNew   = 2'd1,
    SrcEntry = 2'd2,
    SrcZero  = 2'd3
  } out_src_e;

  typedef struct packed {
    logic     capture;
    logic     k_clr;
    logic     k_inc;
    logic     rd_en;
    logic     do_insert;
    logic     do_remove;
    logic     wr_last;
    logic     load_out;
    logic [2:0] out_status;
    out_src_e out_src;
    logic     out_last;
  } rrt_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       reply_ok;
    logic       full;
    logic       scan_end;
    logic       hit;
    logic       expired;
    logic       resend;
    logic       out_busy;
  } rrt_stat_t;

endpackage

[rtl/core/rrt_ctrl.sv]
`timescale 1ns / 1ps

module rrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rrt_pkg::rrt_stat_t stat_i,
  output rrt_pkg::rrt_cmd_t  cmd_o
);

  localparam logic [1:0] SIdle     = 2'd0;
  localparam logic [1:0] SDispatch = 2'd1;
  localparam logic [1:0] SRead     = 2'd2;
  localparam logic [1:0] SCheck    = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SDispatch;
        end
      end
      SDispatch: begin
        case (stat_i.req_type)
          rrt_pkg::ReqNew: begin
            if (!stat_i.out_busy) begin
              cmd_o.load_out = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = rrt_pkg::StsFull;
                cmd_o.out_src    = rrt_pkg::SrcEcho;
              end else begin
                cmd_o.do_insert  = 1'b1;
                cmd_o.out_status = rrt_pkg::StsStored;
                cmd_o.out_src    = rrt_pkg::SrcNew;
              end
              state_d = SIdle;
            end
          end
          rrt_pkg::ReqReply: begin
            if (!stat_i.reply_ok) begin
              if (!stat_i.out_busy) begin
                cmd_o.load_out   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = rrt_pkg::StsIgnored;
                cmd_o.out_src    = rrt_pkg::SrcEcho;
                state_d          = SIdle;
              end
            end else begin
              cmd_o.k_clr = 1'b1;
              state_d     = SRead;
            end
          end
          rrt_pkg::ReqTick: begin
            cmd_o.k_clr = 1'b1;
            state_d     = SRead;
          end
          default: begin
            state_d = SIdle;
          end
        endcase
      end
      SRead: begin
        if (stat_i.scan_end) begin
          if (!stat_i.out_busy) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_last = 1'b1;
            if (stat_i.req_type == rrt_pkg::ReqReply) begin
              cmd_o.out_status = rrt_pkg::StsUnmatched;
              cmd_o.out_src    = rrt_pkg::SrcEcho;
            end else begin
              cmd_o.out_status = rrt_pkg::StsTickDone;
              cmd_o.out_src    = rrt_pkg::SrcZero;
            end
            state_d = SIdle;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = SCheck;
        end
      end
      SCheck: begin
        if (stat_i.req_type == rrt_pkg::ReqReply) begin
          if (stat_i.hit) begin
            if (!stat_i.out_busy) begin
              cmd_o.do_remove  = 1'b1;
              cmd_o.load_out   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_status = rrt_pkg::StsMatched;
              cmd_o.out_src    = rrt_pkg::SrcEntry;
              state_d          = SIdle;
            end
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = SRead;
          end
        end else if (stat_i.expired) begin
          // removal shifts the next entry into this rank: hold k
          if (!stat_i.out_busy) begin
            cmd_o.do_remove  = 1'b1;
            cmd_o.load_out   = 1'b1;
            cmd_o.out_status = rrt_pkg::StsExpired;
            cmd_o.out_src    = rrt_pkg::SrcEntry;
            state_d          = SRead;
          end
        end else if (stat_i.resend) begin
          if (!stat_i.out_busy) begin
            cmd_o.wr_last    = 1'b1;
            cmd_o.load_out   = 1'b1;
            cmd_o.out_status = rrt_pkg::StsResend;
            cmd_o.out_src    = rrt_pkg::SrcEntry;
            cmd_o.k_inc      = 1'b1;
            state_d          = SRead;
          end
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = SRead;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule

[rtl/core/rrt_dp.sv]
`timescale 1ns / 1ps

module rrt_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          req_type_i,
  input  logic [rrt_pkg::IdW-1:0]             trans_id_i,
  input  logic [rrt_pkg::AddrW-1:0]           dest_addr_i,
  input  logic [rrt_pkg::PortW-1:0]           dest_port_i,
  input  logic [31:0]                         reply_kind_i,
  input  logic                                reply_long_enough_i,
  input  logic [rrt_pkg::TimeW-1:0]           now_sec_i,
  input  logic                                cfg_valid_i,
  input  logic [rrt_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rrt_pkg::CfgW-1:0]            cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          status_o,
  output logic [3:0]                          slot_o,
  output logic [rrt_pkg::IdW-1:0]             out_trans_id_o,
  output logic [rrt_pkg::AddrW-1:0]           out_addr_o,
  output logic [rrt_pkg::PortW-1:0]           out_port_o,
  output logic                                last_o,
  input  rrt_pkg::rrt_cmd_t                   cmd_i,
  output rrt_pkg::rrt_stat_t                  stat_o
);

  localparam int Depth = rrt_pkg::TableDepth;
  localparam int SlotW = rrt_pkg::SlotW;
  localparam int CntW  = rrt_pkg::CntW;
  localparam int TimeW = rrt_pkg::TimeW;
  localparam int KeyW  = rrt_pkg::KeyW;

  // Configuration
  logic [rrt_pkg::CfgW-1:0] resend_gap_q, lifetime_q;

  // Captured request
  logic [1:0]                req_type_q;
  logic [rrt_pkg::IdW-1:0]   id_q;
  logic [rrt_pkg::AddrW-1:0] addr_q;
  logic [rrt_pkg::PortW-1:0] port_q;
  logic                      reply_ok_q;
  logic [TimeW-1:0]          now_q;

  // Table control: valid bits, age order (index 0 = newest), fill count, scan pointer
  logic [Depth-1:0]  valid_q;
  logic [SlotW-1:0]  order_q [Depth];
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   k_q;

  // Entry storage
  logic [KeyW-1:0]    key_mem  [Depth];
  logic [2*TimeW-1:0] time_mem [Depth];
  logic [KeyW-1:0]    key_rd_q;
  logic [2*TimeW-1:0] time_rd_q;
  logic [SlotW-1:0]   rd_slot_q;

  // Result register
  logic                      out_valid_q;
  logic [2:0]                status_q;
  logic [SlotW-1:0]          slot_q;
  logic [rrt_pkg::IdW-1:0]   out_id_q;
  logic [rrt_pkg::AddrW-1:0] out_addr_q;
  logic [rrt_pkg::PortW-1:0] out_port_q;
  logic                      last_q;

  logic [SlotW-1:0]   free_slot;
  logic [SlotW-1:0]   scan_slot;
  logic [TimeW:0]     exp_sum;
  logic [TimeW-1:0]   exp_sat;
  logic [TimeW-1:0]   rd_last, rd_exp;
  logic [TimeW:0]     resend_at;
  logic [SlotW-1:0]   wr_slot;

  always_comb begin
    free_slot = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SlotW'(i);
      end
    end
  end

  assign scan_slot = order_q[k_q[SlotW-1:0]];
  assign exp_sum   = {1'b0, now_q} + (TimeW + 1)'(lifetime_q);
  assign exp_sat   = exp_sum[TimeW] ? '1 : exp_sum[TimeW-1:0];
  assign rd_last   = time_rd_q[2*TimeW-1:TimeW];
  assign rd_exp    = time_rd_q[TimeW-1:0];
  assign resend_at = {1'b0, rd_last} + (TimeW + 1)'(resend_gap_q);
  assign wr_slot   = cmd_i.do_insert ? free_slot : rd_slot_q;

  always_comb begin
    stat_o          = '0;
    stat_o.req_type = req_type_q;
    stat_o.reply_ok = reply_ok_q;
    stat_o.full     = (count_q == CntW'(Depth));
    stat_o.scan_end = (k_q == count_q);
    stat_o.hit      = (key_rd_q == {id_q, addr_q, port_q});
    stat_o.expired  = (now_q > rd_exp);
    stat_o.resend   = ({1'b0, now_q} > resend_at);
    stat_o.out_busy = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resend_gap_q <= rrt_pkg::CfgW'(1);
      lifetime_q   <= rrt_pkg::CfgW'(7);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rrt_pkg::CfgResendGap) begin
        resend_gap_q <= cfg_data_i;
      end
      if (cfg_index_i == rrt_pkg::CfgLifetime) begin
        lifetime_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      id_q       <= trans_id_i;
      addr_q     <= dest_addr_i;
      port_q     <= dest_port_i;
      reply_ok_q <= reply_long_enough_i && (reply_kind_i == 32'd1);
      now_q      <= now_sec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + CntW'(1);
      end
      if (cmd_i.do_insert) begin
        valid_q[free_slot] <= 1'b1;
        count_q            <= count_q + CntW'(1);
      end else if (cmd_i.do_remove) begin
        valid_q[rd_slot_q] <= 1'b0;
        count_q            <= count_q - CntW'(1);
      end
    end
  end

  // Age order: insert pushes at the front, removal closes the gap at k
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_insert) begin
      order_q[0] <= free_slot;
      for (int i = 1; i < Depth; i++) begin
        order_q[i] <= order_q[i-1];
      end
    end else if (cmd_i.do_remove) begin
      for (int i = 0; i < Depth - 1; i++) begin
        if (CntW'(i) >= k_q) begin
          order_q[i] <= order_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_insert) begin
      key_mem[free_slot] <= {id_q, addr_q, port_q};
    end
    if (cmd_i.do_insert || cmd_i.wr_last) begin
      time_mem[wr_slot] <= {now_q, (cmd_i.do_insert ? exp_sat : rd_exp)};
    end
    if (cmd_i.rd_en) begin
      key_rd_q  <= key_mem[scan_slot];
      time_rd_q <= time_mem[scan_slot];
      rd_slot_q <= scan_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q <= cmd_i.out_status;
      last_q   <= cmd_i.out_last;
      case (cmd_i.out_src)
        rrt_pkg::SrcEcho: begin
          slot_q     <= '0;
          out_id_q   <= id_q;
          out_addr_q <= addr_q;
          out_port_q <= port_q;
        end
        rrt_pkg::SrcNew: begin
          slot_q     <= free_slot;
          out_id_q   <= id_q;
          out_addr_q <= addr_q;
          out_port_q <= port_q;
        end
        rrt_pkg::SrcEntry: begin
          slot_q                           <= rd_slot_q;
          {out_id_q, out_addr_q, out_port_q} <= key_rd_q;
        end
        default: begin
          slot_q     <= '0;
          out_id_q   <= '0;
          out_addr_q <= '0;
          out_port_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_o         = 4'(slot_q);
  assign out_trans_id_o = out_id_q;
  assign out_addr_o     = out_addr_q;
  assign out_port_o     = out_port_q;
  assign last_o         = last_q;

endmodule

[rtl/core/request_retransmit_table.sv]
`timescale 1ns / 1ps
// New request or ignored reply: result loaded in dispatch once the result register is free.
// Reply lookup walks the age list newest first via read and check states, to a hit or the end.
// Tick walks all entries, gives beats for expired and resent ones and ends with a tick-done beat.
// One item at a time; the next beat is taken once the final result is loaded.
// Reset (async, active low) empties the table at once and sets resend_gap 1, lifetime 7.

module request_retransmit_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [rrt_pkg::IdW-1:0]       trans_id_i,
  input  logic [rrt_pkg::AddrW-1:0]     dest_addr_i,
  input  logic [rrt_pkg::PortW-1:0]     dest_port_i,
  input  logic [31:0]                   reply_kind_i,
  input  logic                          reply_long_enough_i,
  input  logic [rrt_pkg::TimeW-1:0]     now_sec_i,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rrt_pkg::CfgW-1:0]      cfg_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [3:0]                    slot_o,
  output logic [rrt_pkg::IdW-1:0]       out_trans_id_o,
  output logic [rrt_pkg::AddrW-1:0]     out_addr_o,
  output logic [rrt_pkg::PortW-1:0]     out_port_o,
  output logic                          last_o
);

  rrt_pkg::rrt_cmd_t  cmd;
  rrt_pkg::rrt_stat_t stat;

  // Register writes go straight into the registers: always accept the beat.
  assign cfg_ready_o = 1'b1;

  // Sequencer: dispatches on request type, steps the scan pointer over the age list
  // and holds whenever a result must be loaded while the result register is still full.
  rrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table: valid bits, age-ordered slot list, entry memories with a registered read
  // port, the captured request and the result register.
  rrt_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_type_i          (req_type_i),
    .trans_id_i          (trans_id_i),
    .dest_addr_i         (dest_addr_i),
    .dest_port_i         (dest_port_i),
    .reply_kind_i        (reply_kind_i),
    .reply_long_enough_i (reply_long_enough_i),
    .now_sec_i           (now_sec_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .slot_o              (slot_o),
    .out_trans_id_o      (out_trans_id_o),
    .out_addr_o          (out_addr_o),
    .out_port_o          (out_port_o),
    .last_o              (last_o),
    .cmd_i               (cmd),
    .stat_o              (stat)
  );

  // A pending result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.load_out |-> !stat.out_busy)
    else $error("result register loaded while still holding a beat");

  // Every freed entry is reported in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.do_remove |-> cmd.load_out)
    else $error("entry freed without a result");

  // Insertion only into a table with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.do_insert |-> !stat.full)
    else $error("insert into a full table");

  // The scan never reads past the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.rd_en |-> !stat.scan_end)
    else $error("scan read beyond the last entry");

endmodule

[sim/request_retransmit_table_tb.sv]
`timescale 1ns / 1ps

module request_retransmit_table_tb;
  import rrt_pkg::*;

  // Request type with no meaning: the block drops it and produces no beat.
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int PoolSize = 8;
  // Cycles to let pass once the last expected beat is out.
  localparam int SettleCycles = 50;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] reply_kind;
    logic        long_ok;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] id;
    logic [31:0] addr;
    logic [15:0] port;
    logic        last;
  } outcome_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        req_type_i;
  logic [IdW-1:0]    trans_id_i;
  logic [AddrW-1:0]  dest_addr_i;
  logic [PortW-1:0]  dest_port_i;
  logic [31:0]       reply_kind_i;
  logic              reply_long_enough_i;
  logic [TimeW-1:0]  now_sec_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]   cfg_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [2:0]        status_o;
  logic [3:0]        slot_o;
  logic [IdW-1:0]    out_trans_id_o;
  logic [AddrW-1:0]  out_addr_o;
  logic [PortW-1:0]  out_port_o;
  logic              last_o;

  request_retransmit_table dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .trans_id_i          (trans_id_i),
    .dest_addr_i         (dest_addr_i),
    .dest_port_i         (dest_port_i),
    .reply_kind_i        (reply_kind_i),
    .reply_long_enough_i (reply_long_enough_i),
    .now_sec_i           (now_sec_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .slot_o              (slot_o),
    .out_trans_id_o      (out_trans_id_o),
    .out_addr_o          (out_addr_o),
    .out_port_o          (out_port_o),
    .last_o              (last_o)
  );

  // Shadow of the request table and of the two registers.
  logic        tbl_valid  [TableDepth];
  logic [31:0] tbl_id     [TableDepth];
  logic [31:0] tbl_addr   [TableDepth];
  logic [15:0] tbl_port   [TableDepth];
  logic [31:0] tbl_sent   [TableDepth];
  logic [31:0] tbl_expiry [TableDepth];
  int          tbl_age    [TableDepth];
  logic [7:0]  gap_cfg;
  logic [7:0]  life_cfg;

  // Beats still owed by the block, oldest first.
  outcome_t outcome_q[$];
  int       mismatch_count;

  // Traffic state: a small pool of keys so replies and duplicates hit the
  // table, a running seconds counter, and a switch that turns idling off.
  logic [31:0] pool_id   [PoolSize];
  logic [31:0] pool_addr [PoolSize];
  logic [15:0] pool_port [PoolSize];
  logic [31:0] clock_now;
  logic        calm;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------
  function automatic void queue_outcome(logic [2:0] status, int slot, logic [31:0] id,
                                        logic [31:0] addr, logic [15:0] port, logic last);
    outcome_t o;
    o.status = status;
    o.slot   = slot[3:0];
    o.id     = id;
    o.addr   = addr;
    o.port   = port;
    o.last   = last;
    outcome_q.push_back(o);
  endfunction

  // Update the shadow table for one accepted request and queue its beats.
  function automatic void apply_request(req_t rq);
    int          free_s;
    int          hit;
    int          r;
    int          s;
    int          order[$];
    logic [32:0] sum;
    case (rq.kind)
      ReqNew: begin
        free_s = -1;
        for (s = 0; s < TableDepth; s++)
          if (!tbl_valid[s] && free_s < 0) free_s = s;
        if (free_s < 0) begin
          // table full: echo the request, store nothing
          queue_outcome(StsFull, 0, rq.id, rq.addr, rq.port, 1'b1);
        end else begin
          for (s = 0; s < TableDepth; s++)
            if (tbl_valid[s]) tbl_age[s]++;
          // expiry saturates instead of wrapping
          sum = {1'b0, rq.now} + 33'(life_cfg);
          tbl_valid[free_s]  = 1'b1;
          tbl_id[free_s]     = rq.id;
          tbl_addr[free_s]   = rq.addr;
          tbl_port[free_s]   = rq.port;
          tbl_sent[free_s]   = rq.now;
          tbl_expiry[free_s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          tbl_age[free_s]    = 0;
          queue_outcome(StsStored, free_s, rq.id, rq.addr, rq.port, 1'b1);
        end
      end
      ReqReply: begin
        hit = -1;
        if (!rq.long_ok || rq.reply_kind != 32'd1) begin
          queue_outcome(StsIgnored, 0, rq.id, rq.addr, rq.port, 1'b1);
        end else begin
          // newest matching entry wins among duplicates
          for (s = 0; s < TableDepth; s++)
            if (tbl_valid[s] && tbl_id[s] == rq.id && tbl_addr[s] == rq.addr &&
                tbl_port[s] == rq.port && (hit < 0 || tbl_age[s] < tbl_age[hit]))
              hit = s;
          if (hit < 0) begin
            queue_outcome(StsUnmatched, 0, rq.id, rq.addr, rq.port, 1'b1);
          end else begin
            tbl_valid[hit] = 1'b0;
            for (s = 0; s < TableDepth; s++)
              if (tbl_valid[s] && tbl_age[s] > tbl_age[hit]) tbl_age[s]--;
            queue_outcome(StsMatched, hit, tbl_id[hit], tbl_addr[hit], tbl_port[hit], 1'b1);
          end
        end
      end
      ReqTick: begin
        // walk newest to oldest
        for (r = 0; r < TableDepth; r++)
          for (s = 0; s < TableDepth; s++)
            if (tbl_valid[s] && tbl_age[s] == r) begin
              order.push_back(s);
              break;
            end
        foreach (order[i]) begin
          s = order[i];
          if (rq.now > tbl_expiry[s]) begin
            tbl_valid[s] = 1'b0;
            queue_outcome(StsExpired, s, tbl_id[s], tbl_addr[s], tbl_port[s], 1'b0);
          end else if ({1'b0, rq.now} > {1'b0, tbl_sent[s]} + 33'(gap_cfg)) begin
            // resend gap compared without wrap
            tbl_sent[s] = rq.now;
            queue_outcome(StsResend, s, tbl_id[s], tbl_addr[s], tbl_port[s], 1'b0);
          end
        end
        // close the age gaps left by expired entries
        r = 0;
        foreach (order[i])
          if (tbl_valid[order[i]]) begin
            tbl_age[order[i]] = r;
            r++;
          end
        queue_outcome(StsTickDone, 0, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: compare each accepted beat with the oldest expectation
  // ---------------------------------------------------------------------
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual status %0d slot %0d id %0h",
                 $time, status_o, slot_o, out_trans_id_o);
      end else begin
        o = outcome_q.pop_front();
        check_field("status", 32'(o.status), 32'(status_o));
        check_field("slot", 32'(o.slot), 32'(slot_o));
        check_field("trans_id", o.id, out_trans_id_o);
        check_field("addr", o.addr, out_addr_o);
        check_field("port", 32'(o.port), 32'(out_port_o));
        check_field("last", 32'(o.last), 32'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result sink: after every beat, hold ready low for a random stall
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      @(negedge clk_i);
      out_ready_i <= (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  function automatic req_t make_req(logic [1:0] kind, logic [31:0] id, logic [31:0] addr,
                                    logic [15:0] port, logic [31:0] reply_kind,
                                    logic long_ok, logic [31:0] now);
    req_t rq;
    rq.kind       = kind;
    rq.id         = id;
    rq.addr       = addr;
    rq.port       = port;
    rq.reply_kind = reply_kind;
    rq.long_ok    = long_ok;
    rq.now        = now;
    return rq;
  endfunction

  // Send one request beat after a random gap; predict at acceptance.
  task automatic send_request(req_t rq);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    req_type_i          <= rq.kind;
    trans_id_i          <= rq.id;
    dest_addr_i         <= rq.addr;
    dest_port_i         <= rq.port;
    reply_kind_i        <= rq.reply_kind;
    reply_long_enough_i <= rq.long_ok;
    now_sec_i           <= rq.now;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(rq);
  endtask

  // Drop valid and hold until every expected beat has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // Bring the block to idle: a request type with no beat may still be in
  // flight once the queue runs dry, so let the worst latency pass too.
  task automatic settle();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_register(logic [CfgIdxW-1:0] idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgResendGap) gap_cfg = value;
    else if (idx == CfgLifetime) life_cfg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic over a shared key pool: stores, matching
  // replies and ticks with slowly advancing time; the rest is noise.
  function automatic req_t random_request();
    req_t rq;
    int   pick;
    int   k;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, PoolSize - 1);
    if ($urandom_range(0, 49) == 0)
      clock_now = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FF00 + $urandom_range(0, 255);
    rq = make_req(ReqNew, $urandom(), $urandom(), 16'($urandom()), $urandom(),
                  1'($urandom()), clock_now);
    if (pick < 40) begin
      if (pick < 15) begin
        // reuse a key: duplicates in the table
        rq.id   = pool_id[k];
        rq.addr = pool_addr[k];
        rq.port = pool_port[k];
      end else begin
        pool_id[k]   = rq.id;
        pool_addr[k] = rq.addr;
        pool_port[k] = rq.port;
      end
    end else if (pick < 70) begin
      rq.kind = ReqReply;
      if (pick < 64) begin
        rq.id   = pool_id[k];
        rq.addr = pool_addr[k];
        rq.port = pool_port[k];
      end
      if (pick < 66) begin
        rq.reply_kind = 32'd1;
        rq.long_ok    = 1'b1;
      end else if (pick < 68) begin
        // right type word but too short
        rq.reply_kind = 32'd1;
        rq.long_ok    = 1'b0;
      end
    end else if (pick < 95) begin
      rq.kind = ReqTick;
      clock_now += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 3);
      rq.now = clock_now;
    end else begin
      rq.kind = ReqUnused;
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Every request type at reset settings, field extremes, duplicate keys,
  // both ignore reasons, saturated expiry and the no-wrap resend compare.
  task automatic test_basic_requests();
    send_request(make_req(ReqNew, '0, '0, '0, '0, 1'b0, '0));
    send_request(make_req(ReqNew, '1, '1, '1, '1, 1'b1, 32'hFFFF_FFFE));
    send_request(make_req(ReqNew, '0, '0, '0, 32'd1, 1'b1, 32'd1));
    send_request(make_req(ReqReply, '0, '0, '0, 32'd1, 1'b0, '1));
    send_request(make_req(ReqReply, '0, '0, '0, '1, 1'b1, '0));
    send_request(make_req(ReqReply, $urandom(), $urandom(), 16'($urandom()), 32'd1, 1'b1,
                          '0));
    send_request(make_req(ReqReply, '0, '0, '0, 32'd1, 1'b1, '0));
    send_request(make_req(ReqUnused, '1, '1, '1, '1, 1'b1, '1));
    send_request(make_req(ReqTick, '1, '1, '1, '1, 1'b1, 32'd3));
    send_request(make_req(ReqTick, '0, '0, '0, '0, 1'b0, '1));
    send_request(make_req(ReqReply, '1, '1, '1, 32'd1, 1'b1, '0));
  endtask

  // Fill every slot, overflow once, then expire the lot in one tick: the
  // longest run of beats a single request can cause.
  task automatic test_full_table();
    settle();
    set_register(CfgResendGap, 8'd0);
    set_register(CfgLifetime, 8'd0);
    repeat (TableDepth)
      send_request(make_req(ReqNew, $urandom(), $urandom(), 16'($urandom()), $urandom(),
                            1'b0, 32'd100));
    send_request(make_req(ReqNew, $urandom(), $urandom(), 16'($urandom()), $urandom(), 1'b1,
                          32'd100));
    send_request(make_req(ReqTick, '0, '0, '0, '0, 1'b0, 32'd100));
    send_request(make_req(ReqTick, '0, '0, '0, '0, 1'b0, 32'd101));
  endtask

  // Random traffic over several register settings, extremes included.
  task automatic test_random_traffic();
    int         sent;
    logic [7:0] gap_v;
    logic [7:0] life_v;
    req_t       rq;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       begin gap_v = 8'd1;   life_v = 8'd7;   end
        1:       begin gap_v = 8'd0;   life_v = 8'd255; end
        2:       begin gap_v = 8'd255; life_v = 8'd0;   end
        3:       begin gap_v = 8'd3;   life_v = 8'd20;  end
        default: begin gap_v = 8'($urandom()); life_v = 8'($urandom()); end
      endcase
      settle();
      set_register(CfgResendGap, gap_v);
      set_register(CfgLifetime, life_v);
      sent = 0;
      while (sent < 60) begin
        if (sent % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        // hold off mid-phase until the block has answered everything
        if (sent == 35) wait_for_results();
        rq = random_request();
        send_request(rq);
        if (rq.kind != ReqUnused) sent++;
      end
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    req_type_i          = ReqNew;
    trans_id_i          = '0;
    dest_addr_i         = '0;
    dest_port_i         = '0;
    reply_kind_i        = '0;
    reply_long_enough_i = 1'b0;
    now_sec_i           = '0;
    cfg_valid_i         = 1'b0;
    cfg_index_i         = CfgResendGap;
    cfg_data_i          = '0;
    mismatch_count      = 0;
    calm                = 1'b0;
    clock_now           = '0;
    gap_cfg             = 8'd1;
    life_cfg            = 8'd7;
    foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;
    foreach (pool_id[k]) begin
      pool_id[k]   = $urandom();
      pool_addr[k] = $urandom();
      pool_port[k] = 16'($urandom());
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_requests();
    test_full_table();
    test_random_traffic();

    // drain, then watch for stray beats
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS request_retransmit_table");
    end else begin
      $display("FAIL request_retransmit_table");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAIL request_retransmit_table");
    $finish;
  end

endmodule
